// File: design/asdrc_pkg.sv
// ----------------------------------------------------------------------------
// asdrc_pkg
// Shared types and constants for the airspeed sensor double-read check.
// ----------------------------------------------------------------------------
package asdrc_pkg;

  localparam int PW  = 14;   // pressure count width
  localparam int TW  = 11;   // temperature count width
  localparam int PSW = 19;   // scaled pressure width (signed)
  localparam int TSW = 15;   // scaled temperature width
  localparam int DW  = 14;   // max_difference width

  localparam logic [PW-1:0] P_FULL  = 14'h3FFF;
  localparam logic [TW-1:0] T_FULL  = 11'h7FF;
  localparam logic [DW-1:0] DIFF_RST = 14'd255;

  // Pressure: round(a * 6894757 / 819150), a = |16383 - 2p|.
  // Reciprocal rounded up; 36 fraction bits keep the error under 1/d for a < 2^14.
  localparam int             P_SHIFT = 36;
  localparam logic [39:0]    P_RECIP = 40'(((64'd6894757 << P_SHIFT) + 64'd819149)
                                           / 64'd819150);
  localparam logic [53:0]    P_HALF  = 54'd1 << (P_SHIFT - 1);
  localparam logic [PW:0]    P_MID   = 15'd16383;

  // Temperature: floor((128000 t + 292354587) / 20470).
  localparam int             T_SHIFT  = 44;
  localparam logic [29:0]    T_RECIP  = 30'(((64'd1 << T_SHIFT) + 64'd20469) / 64'd20470);
  localparam logic [29:0]    T_SCALE  = 30'd128000;
  localparam logic [29:0]    T_OFFSET = 30'd292354587;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_STATUS   = 2'd1,
    ERR_LIMIT    = 2'd2,
    ERR_DISAGREE = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [PW-1:0] p;
    logic [TW-1:0] t;
    logic          at_limit;
  } lane_info_t;

  typedef struct packed {
    err_code_t     err;
    logic [PW-1:0] p;
    logic [TW-1:0] t;
  } merge_t;

  typedef struct packed {
    logic en_mid;
    logic en_out;
  } scale_ctrl_t;

endpackage

// File: design/asdrc_lane.sv
// ----------------------------------------------------------------------------
// asdrc_lane
// One frame lane: unpacks pressure and temperature counts, flags limit counts.
// ----------------------------------------------------------------------------
module asdrc_lane
  import asdrc_pkg::*;
(
  input  logic [31:0] frame,
  output lane_info_t  info
);

  logic [PW-1:0] p;
  logic [TW-1:0] t;

  assign p = frame[29:16];
  assign t = frame[15:5];   // low five bits unused

  assign info.p        = p;
  assign info.t        = t;
  assign info.at_limit = (p == '0) || (p == P_FULL) || (t == '0) || (t == T_FULL);

endmodule

// File: design/asdrc_merge.sv
// ----------------------------------------------------------------------------
// asdrc_merge
// Combines both lanes: status, limit and agreement checks, averaged counts.
// ----------------------------------------------------------------------------
module asdrc_merge
  import asdrc_pkg::*;
(
  input  lane_info_t    lane0,
  input  lane_info_t    lane1,
  input  logic [1:0]    status,
  input  logic [DW-1:0] max_diff,
  input  logic [PW-1:0] last_p,
  input  logic [TW-1:0] last_t,
  output merge_t        res
);

  logic [PW-1:0] p_gap;
  logic [TW-1:0] t_gap;
  logic [PW:0]   p_sum;
  logic [TW:0]   t_sum;
  logic          disagree;
  err_code_t     err;

  always_comb begin
    p_gap    = (lane0.p > lane1.p) ? (lane0.p - lane1.p) : (lane1.p - lane0.p);
    t_gap    = (lane0.t > lane1.t) ? (lane0.t - lane1.t) : (lane1.t - lane0.t);
    disagree = (p_gap > max_diff) || ({3'b000, t_gap} > max_diff);
    p_sum    = {1'b0, lane0.p} + {1'b0, lane1.p};
    t_sum    = {1'b0, lane0.t} + {1'b0, lane1.t};

    priority if (status[1]) begin
      err = ERR_STATUS;
    end else if (lane0.at_limit || lane1.at_limit) begin
      err = ERR_LIMIT;
    end else if (disagree) begin
      err = ERR_DISAGREE;
    end else begin
      err = ERR_OK;
    end

    res.err = err;
    res.p   = (err == ERR_OK) ? p_sum[PW:1] : last_p;
    res.t   = (err == ERR_OK) ? t_sum[TW:1] : last_t;
  end

endmodule

// File: design/asdrc_scale.sv
// ----------------------------------------------------------------------------
// asdrc_scale
// Two-stage fixed-point scaling of the stored counts to Pa/16 and K/64.
// ----------------------------------------------------------------------------
module asdrc_scale
  import asdrc_pkg::*;
(
  input  logic                  clk,
  input  scale_ctrl_t           ctrl,
  input  merge_t                in_res,
  output err_code_t             err,
  output logic [PW-1:0]         p_count,
  output logic [TW-1:0]         t_count,
  output logic signed [PSW-1:0] p_scaled,
  output logic [TSW-1:0]        t_scaled
);

  // stage 2: magnitude and temperature numerator
  merge_t        mid_r;
  logic          neg_mid_r;
  logic [PW-1:0] mag_mid_r;
  logic [29:0]   tnum_mid_r;

  // stage 3: products
  merge_t        out_r;
  logic          neg_out_r;
  logic [53:0]   pprod_r;
  logic [59:0]   tprod_r;

  logic [PW:0]   p2;
  logic [PW:0]   mag_nxt;
  logic [53:0]   pround;
  logic [PSW-1:0] pmag;

  always_comb begin
    p2      = {in_res.p, 1'b0};
    // p >= 8192 means 16383 - 2p is negative
    mag_nxt = in_res.p[PW-1] ? (p2 - P_MID) : (P_MID - p2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_mid) begin
      mid_r      <= in_res;
      neg_mid_r  <= in_res.p[PW-1];
      mag_mid_r  <= mag_nxt[PW-1:0];
      tnum_mid_r <= (T_SCALE * 30'(in_res.t)) + T_OFFSET;
    end
    if (ctrl.en_out) begin
      out_r     <= mid_r;
      neg_out_r <= neg_mid_r;
      pprod_r   <= 54'(mag_mid_r) * 54'(P_RECIP);
      tprod_r   <= 60'(tnum_mid_r) * 60'(T_RECIP);
    end
  end

  always_comb begin
    pround   = pprod_r + P_HALF;
    pmag     = {1'b0, pround[53:P_SHIFT]};
    p_scaled = neg_out_r ? -pmag : pmag;   // symmetric: ties away from zero
    t_scaled = tprod_r[T_SHIFT +: TSW];
    err      = out_r.err;
    p_count  = out_r.p;
    t_count  = out_r.t;
  end

endmodule

// File: design/airspeed_sensor_double_read_check.sv
// ----------------------------------------------------------------------------
// airspeed_sensor_double_read_check
// Double-read plausibility check and scaling for a differential pressure sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: two four-byte frames
//   read back to back from the sensor. Result channel (out_valid/out_ready)
//   returns exactly one item per input item, in order.
//   Config channel (cfg_valid/cfg_ready) writes max_difference; cfg_ready is
//   always high. Write it only while no items are in flight.
//   Two lanes unpack and limit-check the frames side by side; a merge stage
//   checks status and agreement and updates the stored counts at accept.
//   An accepted item passes the merge register, scale numerator stage and
//   multiplier stage. Throughput: one item per cycle unless the receiver
//   stalls, set by the three-stage pipeline with one multiplier per quantity.
//   Each stage loads whenever it is empty or the stage after it moves, so a
//   stalled receiver holds the result steady while bubbles still fill; input
//   stalls only when all three stages are full.
//   Reset (rst_n low, synchronous): pipeline empty, stored counts zero,
//   max_difference back to 255.
// ----------------------------------------------------------------------------
module airspeed_sensor_double_read_check
  import asdrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DW-1:0]         cfg_max_difference,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_first_frame,
  input  logic [31:0]           in_second_frame,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_data_valid,
  output logic [1:0]            out_error_code,
  output logic [PW-1:0]         out_pressure_count,
  output logic [TW-1:0]         out_temperature_count,
  output logic signed [PSW-1:0] out_pressure_sixteenth_pa,
  output logic [TSW-1:0]        out_temperature_sixtyfourth_k
);

  logic [DW-1:0] max_diff_r;
  logic [PW-1:0] last_p_r;
  logic [TW-1:0] last_t_r;

  // pipeline occupancy: merge, mid, out stages
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic accept;

  lane_info_t  lane0, lane1;
  merge_t      merged;
  merge_t      s1_r;
  scale_ctrl_t sctrl;
  err_code_t   err_out;

  assign cfg_ready = 1'b1;

  assign en3    = !v3_r || out_ready;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_ready = en1;
  assign accept = in_valid && in_ready;

  asdrc_lane u_lane0 (.frame(in_first_frame),  .info(lane0));
  asdrc_lane u_lane1 (.frame(in_second_frame), .info(lane1));

  asdrc_merge u_merge (
    .lane0    (lane0),
    .lane1    (lane1),
    .status   (in_first_frame[31:30]),   // second frame status is ignored
    .max_diff (max_diff_r),
    .last_p   (last_p_r),
    .last_t   (last_t_r),
    .res      (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_diff_r <= DIFF_RST;
      last_p_r   <= '0;
      last_t_r   <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_diff_r <= cfg_max_difference;
      end
      // merged.p/t already fall back to the stored counts on a failed pair
      if (accept) begin
        last_p_r <= merged.p;
        last_t_r <= merged.t;
      end
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= merged;
    end
  end

  assign sctrl.en_mid = en2 && v1_r;
  assign sctrl.en_out = en3 && v2_r;

  asdrc_scale u_scale (
    .clk      (clk),
    .ctrl     (sctrl),
    .in_res   (s1_r),
    .err      (err_out),
    .p_count  (out_pressure_count),
    .t_count  (out_temperature_count),
    .p_scaled (out_pressure_sixteenth_pa),
    .t_scaled (out_temperature_sixtyfourth_k)
  );

  assign out_valid      = v3_r;
  assign out_error_code = err_out;
  assign out_data_valid = (err_out == ERR_OK);

endmodule

// File: design/asdrc_checker.sv
// ----------------------------------------------------------------------------
// asdrc_checker
// Port-level checks on the double-read check block, bound to the top level.
// ----------------------------------------------------------------------------
module asdrc_checker
  import asdrc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_data_valid,
  input logic [1:0]            out_error_code,
  input logic [PW-1:0]         out_pressure_count,
  input logic [TW-1:0]         out_temperature_count,
  input logic signed [PSW-1:0] out_pressure_sixteenth_pa
);

  // scaled pressure and error code held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_sixteenth_pa)
      && $stable(out_error_code))
    else $error("result changed under stall");

  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data_valid == (out_error_code == ERR_OK)))
    else $error("data_valid disagrees with error code");

  // an accepted pair averages two in-range counts, so it cannot sit at a limit
  a_good_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_pressure_count != '0
      && out_pressure_count != P_FULL && out_temperature_count != '0
      && out_temperature_count != T_FULL)
    else $error("accepted pair reports a limit count");

  // counts above mid scale read as negative pressure
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressure_sixteenth_pa[PSW-1] == out_pressure_count[PW-1]))
    else $error("pressure sign mismatch");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind airspeed_sensor_double_read_check asdrc_checker u_asdrc_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .out_valid                 (out_valid),
  .out_ready                 (out_ready),
  .out_data_valid            (out_data_valid),
  .out_error_code            (out_error_code),
  .out_pressure_count        (out_pressure_count),
  .out_temperature_count     (out_temperature_count),
  .out_pressure_sixteenth_pa (out_pressure_sixteenth_pa)
);
